[design/rotate_vector_euler_xyz_top_assert.svh]
// assertion macros for the euler xyz rotation block
`ifndef ROTATE_VECTOR_EULER_XYZ_TOP_ASSERT_SVH
`define ROTATE_VECTOR_EULER_XYZ_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define RVE_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("rvexyz assertion failed");

`define RVE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvexyz assertion failed");

`define RVE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvexyz assertion failed");

`else

`define RVE_ASSERT_DLY(lbl, ante, dly, cons)
`define RVE_ASSERT_IMP(lbl, ante, cons)
`define RVE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[design/rvexyz_pkg.sv]
`default_nettype none

package rvexyz_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = $clog2(CORDIC_STAGES);

    localparam int ANG_W   = 26;
    localparam int ZANG_W  = 33;
    localparam int COORD_W = 52;
    localparam int VEC_W   = 32;

    localparam int DEG360 = 23592960;
    localparam int DEG180 = 11796480;
    localparam int DEG90  = 5898240;

    localparam int CFG_SETTLE = 2;
    localparam int RESULT_LAT = 3 * CORDIC_STAGES + 13;

    localparam logic signed [VEC_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VEC_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic [STG_W-1:0]                stg_t;
    typedef logic signed [ANG_W-1:0]         angle_t;
    typedef logic signed [ZANG_W-1:0]        zang_t;
    typedef logic signed [COORD_W-1:0]       coord_t;
    typedef logic signed [COORD_W:0]         ext_t;
    typedef logic signed [VEC_W-1:0]         vec_t;

    typedef struct packed {
        logic  flip;
        zang_t zang;
    } ang_t;

    typedef enum logic [1:0] {
        REG_ANGLE_X = 2'd0,
        REG_ANGLE_Y = 2'd1,
        REG_ANGLE_Z = 2'd2
    } cfg_idx_t;

    // atan(2^-i) in degrees with 24 fraction bits
    function automatic logic [29:0] atan_tab(input logic [4:0] idx);
        logic [29:0] r;
        case (idx)
            5'd0:    r = 30'd754974720;
            5'd1:    r = 30'd445687602;
            5'd2:    r = 30'd235489088;
            5'd3:    r = 30'd119537938;
            5'd4:    r = 30'd60000934;
            5'd5:    r = 30'd30029717;
            5'd6:    r = 30'd15018523;
            5'd7:    r = 30'd7509720;
            5'd8:    r = 30'd3754917;
            5'd9:    r = 30'd1877466;
            5'd10:   r = 30'd938734;
            5'd11:   r = 30'd469367;
            5'd12:   r = 30'd234684;
            5'd13:   r = 30'd117342;
            5'd14:   r = 30'd58671;
            5'd15:   r = 30'd29335;
            5'd16:   r = 30'd14668;
            5'd17:   r = 30'd7334;
            5'd18:   r = 30'd3667;
            5'd19:   r = 30'd1833;
            5'd20:   r = 30'd917;
            5'd21:   r = 30'd458;
            5'd22:   r = 30'd229;
            5'd23:   r = 30'd115;
            5'd24:   r = 30'd57;
            5'd25:   r = 30'd29;
            5'd26:   r = 30'd14;
            5'd27:   r = 30'd7;
            5'd28:   r = 30'd4;
            5'd29:   r = 30'd2;
            5'd30:   r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // squared cordic gain in q.60, elaboration only
    function automatic logic [63:0] gain_sq();
        logic [63:0] g;
        g = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            g = g + (g >> (2 * i));
        end
        return g;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bv;
        logic [63:0] rem;
        res = 64'd0;
        bv  = 64'd1 << 62;
        rem = n;
        while (bv > rem)
        begin
            bv = bv >> 2;
        end
        while (bv != 64'd0)
        begin
            if (rem >= res + bv)
            begin
                rem = rem - (res + bv);
                res = (res >> 1) + bv;
            end
            else
            begin
                res = res >> 1;
            end
            bv = bv >> 2;
        end
        return res;
    endfunction

    localparam logic [63:0] GAIN_SQRT     = isqrt64(gain_sq());
    localparam logic [63:0] INV_GAIN_FULL = ((64'd1 << 62) + (GAIN_SQRT >> 1)) / GAIN_SQRT;
    localparam logic [31:0] INV_GAIN      = INV_GAIN_FULL[31:0];

    // q.32 to q16.16, round half up, saturate
    function automatic vec_t sat_q16(input ext_t v);
        logic signed [COORD_W+1:0]  s;
        logic signed [COORD_W-15:0] r;
        s = (COORD_W+2)'(v) + (COORD_W+2)'(32768);
        r = s[COORD_W+1:16];
        if (r > Q_MAX)
        begin
            return Q_MAX;
        end
        else if (r < Q_MIN)
        begin
            return Q_MIN;
        end
        return r[VEC_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/rotate_vector_euler_xyz_top.sv]
// Euler xyz rotation of a q16.16 vector: about x, then y, then z.
// Command channel: a vector transaction is taken at a rising edge with start
// high and busy low. Every cycle with busy low may carry one, so the sustained
// rate is one vector per clock while busy stays low; the row of cordic
// micro-rotation cells, one per stage in each of the three planes, sets that figure.
// Result: done is high for one cycle with rot_x, rot_y and rot_z_neg valid;
// it is registered from the valid that leaves the z plane, after the vector
// has passed the x, y and z planes in turn.
// The receiver cannot stall; results are never held back.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data writes one
// of angle_x, angle_y, angle_z; cfg_ready is always high and other indexes
// are dropped. After a config transaction busy is high while the angle is
// reduced. Write angles only with no vector in flight.
// Reset: angles clear to zero, the pipeline empties, busy is low.
`default_nettype none

`include "rotate_vector_euler_xyz_top_assert.svh"

module rotate_vector_euler_xyz_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          vec_x,
    input  logic signed [31:0]          vec_y,
    input  logic signed [31:0]          vec_z,
    output logic                        done,
    output logic signed [31:0]          rot_x,
    output logic signed [31:0]          rot_y,
    output logic signed [31:0]          rot_z_neg,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic signed [25:0]          cfg_data
);

    rvexyz_pkg::angle_t angle_x_reg;
    rvexyz_pkg::angle_t angle_y_reg;
    rvexyz_pkg::angle_t angle_z_reg;
    logic [1:0]         settle_reg;
    logic               cfg_wr;
    logic               accept;

    rvexyz_pkg::ang_t   ang_x;
    rvexyz_pkg::ang_t   ang_y;
    rvexyz_pkg::ang_t   ang_z;

    rvexyz_pkg::coord_t in_x;
    rvexyz_pkg::coord_t in_y;
    rvexyz_pkg::coord_t in_z;

    logic               p1_vld;
    rvexyz_pkg::coord_t p1_a;
    rvexyz_pkg::coord_t p1_b;
    rvexyz_pkg::coord_t p1_c;
    logic               p2_vld;
    rvexyz_pkg::coord_t p2_a;
    rvexyz_pkg::coord_t p2_b;
    rvexyz_pkg::coord_t p2_c;
    logic               p3_vld;
    rvexyz_pkg::coord_t p3_a;
    rvexyz_pkg::coord_t p3_b;
    rvexyz_pkg::coord_t p3_c;

    rvexyz_pkg::ext_t   z_neg;
    logic               done_reg;
    rvexyz_pkg::vec_t   rot_x_reg;
    rvexyz_pkg::vec_t   rot_y_reg;
    rvexyz_pkg::vec_t   rot_z_neg_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign busy      = (settle_reg != 2'd0);
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            settle_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr)
            begin
                settle_reg <= 2'(rvexyz_pkg::CFG_SETTLE);
                case (cfg_index)
                    rvexyz_pkg::REG_ANGLE_X: angle_x_reg <= cfg_data;
                    rvexyz_pkg::REG_ANGLE_Y: angle_y_reg <= cfg_data;
                    rvexyz_pkg::REG_ANGLE_Z: angle_z_reg <= cfg_data;
                    default:                 ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    rvexyz_angle u_angle_x (.clk(clk), .rst_n(rst_n), .raw(angle_x_reg), .ang(ang_x));
    rvexyz_angle u_angle_y (.clk(clk), .rst_n(rst_n), .raw(angle_y_reg), .ang(ang_y));
    rvexyz_angle u_angle_z (.clk(clk), .rst_n(rst_n), .raw(angle_z_reg), .ang(ang_z));

    // q16.16 to q.32
    assign in_x = rvexyz_pkg::coord_t'($signed({vec_x, 16'h0000}));
    assign in_y = rvexyz_pkg::coord_t'($signed({vec_y, 16'h0000}));
    assign in_z = rvexyz_pkg::coord_t'($signed({vec_z, 16'h0000}));

    // y,z plane
    rvexyz_plane u_plane_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .ang     (ang_x),
        .vld_in  (accept),
        .a_in    (in_y),
        .b_in    (in_z),
        .c_in    (in_x),
        .vld_out (p1_vld),
        .a_out   (p1_a),
        .b_out   (p1_b),
        .c_out   (p1_c)
    );

    // z,x plane
    rvexyz_plane u_plane_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .ang     (ang_y),
        .vld_in  (p1_vld),
        .a_in    (p1_b),
        .b_in    (p1_c),
        .c_in    (p1_a),
        .vld_out (p2_vld),
        .a_out   (p2_a),
        .b_out   (p2_b),
        .c_out   (p2_c)
    );

    // x,y plane
    rvexyz_plane u_plane_z (
        .clk     (clk),
        .rst_n   (rst_n),
        .ang     (ang_z),
        .vld_in  (p2_vld),
        .a_in    (p2_b),
        .b_in    (p2_c),
        .c_in    (p2_a),
        .vld_out (p3_vld),
        .a_out   (p3_a),
        .b_out   (p3_b),
        .c_out   (p3_c)
    );

    assign z_neg = -rvexyz_pkg::ext_t'(p3_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p3_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_x_reg     <= rvexyz_pkg::sat_q16(rvexyz_pkg::ext_t'(p3_a));
        rot_y_reg     <= rvexyz_pkg::sat_q16(rvexyz_pkg::ext_t'(p3_b));
        rot_z_neg_reg <= rvexyz_pkg::sat_q16(z_neg);
    end

    assign done      = done_reg;
    assign rot_x     = rot_x_reg;
    assign rot_y     = rot_y_reg;
    assign rot_z_neg = rot_z_neg_reg;

    `RVE_ASSERT_DLY(a_result_latency, start && !busy, rvexyz_pkg::RESULT_LAT, done)
    `RVE_ASSERT_IMP(a_result_has_cause, done, $past(start && !busy, rvexyz_pkg::RESULT_LAT))
    `RVE_ASSERT_NXT(a_cfg_blocks_start, cfg_valid && cfg_ready, busy)

endmodule

`default_nettype wire

[design/rvexyz_angle.sv]
`default_nettype none

module rvexyz_angle (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rvexyz_pkg::angle_t   raw,
    output rvexyz_pkg::ang_t     ang
);

    rvexyz_pkg::angle_t           wrap_reg;
    rvexyz_pkg::angle_t           wrap_next;
    logic signed [rvexyz_pkg::ANG_W:0] wrap_sum;
    rvexyz_pkg::angle_t           fold;
    rvexyz_pkg::ang_t             ang_reg;
    rvexyz_pkg::ang_t             ang_next;

    // wrap to [-180, 180)
    always_comb
    begin
        if (raw >= rvexyz_pkg::DEG180)
        begin
            wrap_sum = (rvexyz_pkg::ANG_W+1)'(raw) - (rvexyz_pkg::ANG_W+1)'(rvexyz_pkg::DEG360);
        end
        else if (raw < -rvexyz_pkg::DEG180)
        begin
            wrap_sum = (rvexyz_pkg::ANG_W+1)'(raw) + (rvexyz_pkg::ANG_W+1)'(rvexyz_pkg::DEG360);
        end
        else
        begin
            wrap_sum = (rvexyz_pkg::ANG_W+1)'(raw);
        end
        wrap_next = wrap_sum[rvexyz_pkg::ANG_W-1:0];
    end

    // fold into +-90 with a half turn of the pair
    always_comb
    begin
        ang_next.flip = 1'b0;
        fold          = wrap_reg;
        if (wrap_reg > rvexyz_pkg::DEG90)
        begin
            fold          = wrap_reg - rvexyz_pkg::angle_t'(rvexyz_pkg::DEG180);
            ang_next.flip = 1'b1;
        end
        else if (wrap_reg < -rvexyz_pkg::DEG90)
        begin
            fold          = wrap_reg + rvexyz_pkg::angle_t'(rvexyz_pkg::DEG180);
            ang_next.flip = 1'b1;
        end
        ang_next.zang = rvexyz_pkg::zang_t'(fold) <<< 8;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= '0;
            ang_reg  <= '0;
        end
        else
        begin
            wrap_reg <= wrap_next;
            ang_reg  <= ang_next;
        end
    end

    assign ang = ang_reg;

endmodule

`default_nettype wire

[design/rvexyz_cell.sv]
`default_nettype none

module rvexyz_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  rvexyz_pkg::stg_t   stage,
    input  logic               vld_in,
    input  rvexyz_pkg::coord_t a_in,
    input  rvexyz_pkg::coord_t b_in,
    input  rvexyz_pkg::coord_t c_in,
    input  rvexyz_pkg::zang_t  z_in,
    output logic               vld_out,
    output rvexyz_pkg::coord_t a_out,
    output rvexyz_pkg::coord_t b_out,
    output rvexyz_pkg::coord_t c_out,
    output rvexyz_pkg::zang_t  z_out
);

    rvexyz_pkg::coord_t a_sh;
    rvexyz_pkg::coord_t b_sh;
    rvexyz_pkg::zang_t  atan;
    rvexyz_pkg::coord_t a_next;
    rvexyz_pkg::coord_t b_next;
    rvexyz_pkg::zang_t  z_next;
    logic               vld_reg;
    rvexyz_pkg::coord_t a_reg;
    rvexyz_pkg::coord_t b_reg;
    rvexyz_pkg::coord_t c_reg;
    rvexyz_pkg::zang_t  z_reg;

    always_comb
    begin
        a_sh = a_in >>> stage;
        b_sh = b_in >>> stage;
        atan = rvexyz_pkg::zang_t'(rvexyz_pkg::atan_tab(5'(stage)));
        if (!z_in[rvexyz_pkg::ZANG_W-1])
        begin
            a_next = a_in - b_sh;
            b_next = b_in + a_sh;
            z_next = z_in - atan;
        end
        else
        begin
            a_next = a_in + b_sh;
            b_next = b_in - a_sh;
            z_next = z_in + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_in;
        z_reg <= z_next;
    end

    assign vld_out = vld_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign c_out   = c_reg;
    assign z_out   = z_reg;

endmodule

`default_nettype wire

[design/rvexyz_comp.sv]
`default_nettype none

module rvexyz_comp (
    input  logic               clk,
    input  rvexyz_pkg::coord_t v_in,
    output rvexyz_pkg::coord_t v_out
);

    logic                               neg1_reg;
    logic [rvexyz_pkg::COORD_W-1:0]     mag_reg;
    logic [rvexyz_pkg::COORD_W-1:0]     mag_next;
    logic                               neg2_reg;
    logic [rvexyz_pkg::COORD_W-1:0]     hi_reg;
    logic [rvexyz_pkg::COORD_W-1:0]     hi_next;
    logic [63:0]                        lo_reg;
    logic [63:0]                        lo_next;
    logic [63:0]                        lo_rnd;
    logic [rvexyz_pkg::COORD_W-1:0]     mag_out;
    rvexyz_pkg::coord_t                 res_reg;
    rvexyz_pkg::coord_t                 res_next;

    assign mag_next = v_in[rvexyz_pkg::COORD_W-1] ? unsigned'(-v_in) : unsigned'(v_in);

    // split magnitude times 1/gain, each product at most 32 by 32
    assign hi_next = rvexyz_pkg::COORD_W'(mag_reg[rvexyz_pkg::COORD_W-1:32])
                   * rvexyz_pkg::COORD_W'(rvexyz_pkg::INV_GAIN);
    assign lo_next = 64'(mag_reg[31:0]) * 64'(rvexyz_pkg::INV_GAIN);

    assign lo_rnd   = lo_reg + 64'h0000_0000_8000_0000;
    assign mag_out  = hi_reg + rvexyz_pkg::COORD_W'(lo_rnd[63:32]);
    assign res_next = neg2_reg ? -$signed(mag_out) : $signed(mag_out);

    always_ff @(posedge clk)
    begin
        neg1_reg <= v_in[rvexyz_pkg::COORD_W-1];
        mag_reg  <= mag_next;
        neg2_reg <= neg1_reg;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        res_reg  <= res_next;
    end

    assign v_out = res_reg;

endmodule

`default_nettype wire

[design/rvexyz_plane.sv]
`default_nettype none

module rvexyz_plane (
    input  logic               clk,
    input  logic               rst_n,
    input  rvexyz_pkg::ang_t   ang,
    input  logic               vld_in,
    input  rvexyz_pkg::coord_t a_in,
    input  rvexyz_pkg::coord_t b_in,
    input  rvexyz_pkg::coord_t c_in,
    output logic               vld_out,
    output rvexyz_pkg::coord_t a_out,
    output rvexyz_pkg::coord_t b_out,
    output rvexyz_pkg::coord_t c_out
);

    logic               vld_pipe [0:rvexyz_pkg::CORDIC_STAGES];
    rvexyz_pkg::coord_t a_pipe   [0:rvexyz_pkg::CORDIC_STAGES];
    rvexyz_pkg::coord_t b_pipe   [0:rvexyz_pkg::CORDIC_STAGES];
    rvexyz_pkg::coord_t c_pipe   [0:rvexyz_pkg::CORDIC_STAGES];
    rvexyz_pkg::zang_t  z_pipe   [0:rvexyz_pkg::CORDIC_STAGES];

    logic               vld0_reg;
    rvexyz_pkg::coord_t a0_reg;
    rvexyz_pkg::coord_t b0_reg;
    rvexyz_pkg::coord_t c0_reg;
    rvexyz_pkg::zang_t  z0_reg;
    rvexyz_pkg::coord_t a0_next;
    rvexyz_pkg::coord_t b0_next;

    logic [2:0]         vld_dly_reg;
    rvexyz_pkg::coord_t c_dly_reg [0:2];

    // half turn of the pair when the angle was folded
    assign a0_next = ang.flip ? -a_in : a_in;
    assign b0_next = ang.flip ? -b_in : b_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg    <= 1'b0;
            vld_dly_reg <= '0;
        end
        else
        begin
            vld0_reg    <= vld_in;
            vld_dly_reg <= {vld_dly_reg[1:0], vld_pipe[rvexyz_pkg::CORDIC_STAGES]};
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg       <= a0_next;
        b0_reg       <= b0_next;
        c0_reg       <= c_in;
        z0_reg       <= ang.zang;
        c_dly_reg[0] <= c_pipe[rvexyz_pkg::CORDIC_STAGES];
        c_dly_reg[1] <= c_dly_reg[0];
        c_dly_reg[2] <= c_dly_reg[1];
    end

    assign vld_pipe[0] = vld0_reg;
    assign a_pipe[0]   = a0_reg;
    assign b_pipe[0]   = b0_reg;
    assign c_pipe[0]   = c0_reg;
    assign z_pipe[0]   = z0_reg;

    for (genvar k = 0; k < rvexyz_pkg::CORDIC_STAGES; k++)
    begin : g_cell
        rvexyz_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .stage   (rvexyz_pkg::stg_t'(k)),
            .vld_in  (vld_pipe[k]),
            .a_in    (a_pipe[k]),
            .b_in    (b_pipe[k]),
            .c_in    (c_pipe[k]),
            .z_in    (z_pipe[k]),
            .vld_out (vld_pipe[k+1]),
            .a_out   (a_pipe[k+1]),
            .b_out   (b_pipe[k+1]),
            .c_out   (c_pipe[k+1]),
            .z_out   (z_pipe[k+1])
        );
    end

    rvexyz_comp u_comp_a (
        .clk   (clk),
        .v_in  (a_pipe[rvexyz_pkg::CORDIC_STAGES]),
        .v_out (a_out)
    );

    rvexyz_comp u_comp_b (
        .clk   (clk),
        .v_in  (b_pipe[rvexyz_pkg::CORDIC_STAGES]),
        .v_out (b_out)
    );

    assign vld_out = vld_dly_reg[2];
    assign c_out   = c_dly_reg[2];

endmodule

`default_nettype wire
